// ===== design/lvs_pkg.sv =====
// Shared types, constants and command codes for the LRU victim selector.
`timescale 1ns / 1ps

package lvs_pkg;

  localparam int WAYS_DEF  = 8;
  localparam int MASK_W    = 8;
  localparam int LIMIT_W   = 4;
  localparam int MAX_ATT   = 8;
  localparam int ACC_W     = 3;
  localparam int FIELD3_W  = 3;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic OP_TOUCH  = 1'b0;
  localparam logic OP_VICTIM = 1'b1;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_NONE      = 3'd0;
  localparam cmd_t CMD_LOAD      = 3'd1;
  localparam cmd_t CMD_TOUCH     = 3'd2;
  localparam cmd_t CMD_TAKE_INV  = 3'd3;
  localparam cmd_t CMD_START_ATT = 3'd4;
  localparam cmd_t CMD_SEARCH    = 3'd5;
  localparam cmd_t CMD_APPLY     = 3'd6;
  localparam cmd_t CMD_OUT       = 3'd7;

  typedef struct packed {
    logic op;
    logic any_inv;
    logic reject;
    logic out_free;
  } status_t;

endpackage

// ===== design/lru_victim_select_with_qbs.sv =====
// Top level: LRU victim selector with query-based rejection and its register port.
`timescale 1ns / 1ps

// Keeps the LRU stack of one cache set and serves one transaction at a time.
// A touch, or a victim request that finds an invalid way, is resolved in the
// start state; a victim request over valid ways makes N attempts (1 to
// attempt_limit, with 0 read as 1, at most 8), each a search over the stack
// registers followed by a promotion. The result then waits in the finish state
// until the output register is free. A new transaction is accepted as soon as the previous
// result has moved into the output register, even if it has not been taken.

module lru_victim_select_with_qbs #(
  parameter int WAYS = lvs_pkg::WAYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // accessed_way[2:0], valid_mask[10:3], eligible_mask[18:11],
  // lower_level_mask[26:19], zero fill
  input  logic [lvs_pkg::IN_DATA_W-1:0]     in_tdata,
  // op[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // victim_way[2:0], took_invalid[3], attempt_used[6:4], reject_count[9:7],
  // hit_position[12:10], zero fill
  output logic [lvs_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lvs_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [lvs_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [lvs_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  logic [lvs_pkg::LIMIT_W-1:0] attempt_limit_r;
  logic                        cfg_sel0;
  lvs_pkg::cmd_t               cmd;
  lvs_pkg::status_t            stat;

  assign cfg_pready = 1'b1;
  assign cfg_sel0   = (cfg_paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attempt_limit_r <= lvs_pkg::LIMIT_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel0) begin
      attempt_limit_r <= cfg_pwdata[lvs_pkg::LIMIT_W-1:0];
    end
  end

  assign cfg_prdata = cfg_sel0 ? lvs_pkg::CFG_DATA_W'(attempt_limit_r) : '0;

  lvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lvs_datapath #(
    .WAYS (WAYS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .attempt_limit (attempt_limit_r),
    .in_tuser      (in_tuser),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule

// ===== design/lvs_ctrl.sv =====
// Controller state machine sequencing touches, invalid fills and victim attempts.
`timescale 1ns / 1ps

module lvs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  lvs_pkg::status_t stat,
  output lvs_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_APPLY  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = lvs_pkg::CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = lvs_pkg::CMD_LOAD;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (stat.op == lvs_pkg::OP_TOUCH) begin
          cmd       = lvs_pkg::CMD_TOUCH;
          state_nxt = S_FINISH;
        end else if (stat.any_inv) begin
          cmd       = lvs_pkg::CMD_TAKE_INV;
          state_nxt = S_FINISH;
        end else begin
          cmd       = lvs_pkg::CMD_START_ATT;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd       = lvs_pkg::CMD_SEARCH;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd       = lvs_pkg::CMD_APPLY;
        state_nxt = stat.reject ? S_SEARCH : S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd       = lvs_pkg::CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/lvs_datapath.sv =====
// Datapath: LRU stack positions, victim search, promotion and result registers.
`timescale 1ns / 1ps

module lvs_datapath #(
  parameter int WAYS = lvs_pkg::WAYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lvs_pkg::cmd_t                   cmd,
  output lvs_pkg::status_t                stat,
  input  logic [lvs_pkg::LIMIT_W-1:0]     attempt_limit,
  input  logic                            in_tuser,
  input  logic [lvs_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lvs_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int WW = $clog2(WAYS);
  localparam int MW = lvs_pkg::MASK_W;
  localparam int F3 = lvs_pkg::FIELD3_W;
  localparam int LW = lvs_pkg::LIMIT_W;

  // latched transaction
  logic                      op_r;
  logic [lvs_pkg::ACC_W-1:0] acc_r;
  logic [MW-1:0]             valid_r, elig_r, lower_r;

  logic [WW-1:0] pos_r [WAYS];
  logic [WW-1:0] pos_nxt [WAYS];

  logic [WW-1:0] pick_r;
  logic [F3-1:0] att_r, rej_r;

  logic [F3-1:0] res_victim_r, res_used_r, res_rej_r, res_hit_r;
  logic          res_inv_r;

  logic                          out_valid_r;
  logic [lvs_pkg::OUT_DATA_W-1:0] out_data_r;

  // per-way masks; ways beyond the mask width read as zero
  logic [WAYS-1:0] wvalid, welig, wlower;
  genvar g;
  generate
    for (g = 0; g < WAYS; g++) begin : g_mask
      if (g < MW) begin : g_in
        assign wvalid[g] = valid_r[g];
        assign welig[g]  = elig_r[g];
        assign wlower[g] = lower_r[g];
      end else begin : g_out
        assign wvalid[g] = 1'b0;
        assign welig[g]  = 1'b0;
        assign wlower[g] = 1'b0;
      end
    end
  endgenerate

  // touch target
  logic          acc_ok;
  logic [WW-1:0] acc_idx;
  assign acc_ok  = (32'(acc_r) < 32'(WAYS));
  assign acc_idx = WW'(acc_r);

  // lowest invalid way
  logic [WW-1:0] inv_way;
  always_comb begin
    inv_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!wvalid[i]) inv_way = WW'(i);
    end
  end

  // eligible way with the greatest nonzero position
  logic [WAYS-1:0] hold;
  logic [WW-1:0]   best_p, pick_sel;
  logic            found;
  always_comb begin
    hold = '0;
    for (int p = 1; p < WAYS; p++) begin
      for (int i = 0; i < WAYS; i++) begin
        if (welig[i] && pos_r[i] == WW'(p)) hold[p] = 1'b1;
      end
    end
    best_p = '0;
    found  = 1'b0;
    for (int p = 1; p < WAYS; p++) begin
      if (hold[p]) begin
        best_p = WW'(p);
        found  = 1'b1;
      end
    end
    pick_sel = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (found && pos_r[i] == best_p) pick_sel = WW'(i);
    end
  end

  // attempt bookkeeping
  logic [LW-1:0] eff_limit;
  logic          last_att, reject;
  always_comb begin
    if (attempt_limit == '0) begin
      eff_limit = LW'(1);
    end else if (32'(attempt_limit) > lvs_pkg::MAX_ATT) begin
      eff_limit = LW'(lvs_pkg::MAX_ATT);
    end else begin
      eff_limit = attempt_limit;
    end
  end
  assign last_att = ((LW'(att_r) + LW'(1)) >= eff_limit);
  assign reject   = !last_att && wlower[pick_r];

  // promotion to MRU
  logic          prom_en;
  logic [WW-1:0] prom_way, old_pos;
  always_comb begin
    prom_en  = 1'b0;
    prom_way = pick_r;
    case (cmd)
      lvs_pkg::CMD_TOUCH: begin
        prom_en  = acc_ok;
        prom_way = acc_idx;
      end
      lvs_pkg::CMD_TAKE_INV: begin
        prom_en  = 1'b1;
        prom_way = inv_way;
      end
      lvs_pkg::CMD_APPLY: begin
        prom_en  = 1'b1;
        prom_way = pick_r;
      end
      default: prom_en = 1'b0;
    endcase
    old_pos = pos_r[prom_way];
    for (int i = 0; i < WAYS; i++) begin
      if (!prom_en) begin
        pos_nxt[i] = pos_r[i];
      end else if (WW'(i) == prom_way) begin
        pos_nxt[i] = '0;
      end else if (pos_r[i] < old_pos) begin
        pos_nxt[i] = pos_r[i] + WW'(1);
      end else begin
        pos_nxt[i] = pos_r[i];
      end
    end
  end

  assign stat.op       = op_r;
  assign stat.any_inv  = ~&wvalid;
  assign stat.reject   = reject;
  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WAYS; i++) pos_r[i] <= WW'(i);
    end else begin
      for (int i = 0; i < WAYS; i++) pos_r[i] <= pos_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      lvs_pkg::CMD_LOAD: begin
        op_r    <= in_tuser;
        acc_r   <= in_tdata[2:0];
        valid_r <= in_tdata[10:3];
        elig_r  <= in_tdata[18:11];
        lower_r <= in_tdata[26:19];
      end
      lvs_pkg::CMD_TOUCH: begin
        res_victim_r <= '0;
        res_inv_r    <= 1'b0;
        res_used_r   <= '0;
        res_rej_r    <= '0;
        res_hit_r    <= acc_ok ? F3'(pos_r[acc_idx]) : '0;
      end
      lvs_pkg::CMD_TAKE_INV: begin
        res_victim_r <= F3'(inv_way);
        res_inv_r    <= 1'b1;
        res_used_r   <= '0;
        res_rej_r    <= '0;
        res_hit_r    <= '0;
      end
      lvs_pkg::CMD_START_ATT: begin
        att_r <= '0;
        rej_r <= '0;
      end
      lvs_pkg::CMD_SEARCH: begin
        pick_r <= pick_sel;
      end
      lvs_pkg::CMD_APPLY: begin
        if (reject) begin
          att_r <= att_r + F3'(1);
          rej_r <= rej_r + F3'(1);
        end else begin
          res_victim_r <= F3'(pick_r);
          res_inv_r    <= 1'b0;
          res_used_r   <= att_r;
          res_rej_r    <= rej_r;
          res_hit_r    <= '0;
        end
      end
      lvs_pkg::CMD_OUT: begin
        out_data_r <= {3'b000, res_hit_r, res_rej_r, res_used_r, res_inv_r, res_victim_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == lvs_pkg::CMD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/lvs_checker.sv =====
// Port-level checker for the LRU victim selector, bound to the top level.
`timescale 1ns / 1ps

module lvs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lvs_pkg::OUT_DATA_W-1:0]    out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every attempt before the accepted one was a rejection
  a_rej_eq_att: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:7] == out_tdata[6:4])
    else $error("reject count differs from attempt number");

  // invalid fill carries no attempt or hit information
  a_inv_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[9:4] == 6'd0 && out_tdata[12:10] == 3'd0)
    else $error("invalid fill with attempt fields");

  // a hit position only comes from a touch
  a_hit_touch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12:10] != 3'd0 |-> out_tdata[9:0] == 10'd0)
    else $error("hit position on victim result");

  // after reset the block is empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind lru_victim_select_with_qbs lvs_checker u_lvs_checker (.*);

// ===== bench/lru_victim_select_with_qbs_test.sv =====
// Self-checking testbench for the LRU victim selector with query-based rejection.
`timescale 1ns / 1ps

module lru_victim_select_with_qbs_test;

  localparam int NWAYS = lvs_pkg::WAYS_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 25;
  localparam int PHASE_ITEMS = 85;
  localparam logic [lvs_pkg::CFG_ADDR_W-1:0] REG_ATTEMPT_LIMIT = 3'd0;

  typedef struct packed {
    logic [2:0] hit_position;
    logic [2:0] reject_count;
    logic [2:0] attempt_used;
    logic       took_invalid;
    logic [2:0] victim_way;
  } lvs_result_t;

  class lru_set_scoreboard;
    bit [2:0] stack_pos [NWAYS];
    bit [3:0] attempt_limit;
    lvs_result_t expected_results[$];
    int unsigned mismatches, checked, n_touch, n_victim, n_invalid, n_reject, n_limits;

    function void reset_state();
      for (int i = 0; i < NWAYS; i++) stack_pos[i] = 3'(i);
      attempt_limit = 4'd1;
    endfunction

    function void set_limit(bit [3:0] v);
      attempt_limit = v;
      n_limits++;
    endfunction

    function void promote(int w);
      bit [2:0] old;
      old = stack_pos[w];
      for (int i = 0; i < NWAYS; i++)
        if (stack_pos[i] < old) stack_pos[i] = stack_pos[i] + 3'd1;
      stack_pos[w] = 3'd0;
    endfunction

    function void accept_request(logic op, logic [lvs_pkg::IN_DATA_W-1:0] data);
      lvs_result_t r;
      logic [2:0] way;
      logic [7:0] valid, elig, lower;
      int lim, pick, best;
      bit found;
      r = '0;
      way = data[2:0];
      valid = data[10:3];
      elig = data[18:11];
      lower = data[26:19];
      found = 1'b0;
      if (op == lvs_pkg::OP_TOUCH) begin
        n_touch++;
        r.hit_position = stack_pos[way];
        promote(int'(way));
      end else begin
        n_victim++;
        for (int i = 0; i < NWAYS; i++)
          if (!found && !valid[i]) begin
            found = 1'b1;
            r.victim_way = 3'(i);
            r.took_invalid = 1'b1;
          end
        if (found) begin
          n_invalid++;
          promote(int'(r.victim_way));
        end else begin
          lim = (attempt_limit == 0) ? 1 :
                (attempt_limit > lvs_pkg::MAX_ATT) ? lvs_pkg::MAX_ATT : attempt_limit;
          for (int a = 0; a < lim; a++) begin
            pick = 0;
            best = 0;
            for (int i = 0; i < NWAYS; i++)
              if (stack_pos[i] > best && elig[i]) begin
                pick = i;
                best = stack_pos[i];
              end
            promote(pick);
            if (a + 1 < lim && lower[pick]) begin
              r.reject_count = r.reject_count + 3'd1;
              n_reject++;
            end else begin
              r.victim_way = 3'(pick);
              r.attempt_used = 3'(a);
              break;
            end
          end
        end
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [lvs_pkg::OUT_DATA_W-1:0] word);
      lvs_result_t got, want;
      got = word[12:0];
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: result %h arrived with nothing expected", $realtime, word);
        return;
      end
      want = expected_results.pop_front();
      if (got !== want || word[15:13] !== 3'b000) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR %0t: exp/got victim_way %0d/%0d took_invalid %0d/%0d ",
                    "attempt_used %0d/%0d reject_count %0d/%0d hit_position %0d/%0d fill 0/%b"},
                   $realtime, want.victim_way, got.victim_way, want.took_invalid,
                   got.took_invalid, want.attempt_used, got.attempt_used, want.reject_count,
                   got.reject_count, want.hit_position, got.hit_position, word[15:13]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // accessed_way, valid, eligible, lower-level, zero fill
  logic [lvs_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = lvs_pkg::OP_TOUCH;              // op
  logic out_tvalid;
  logic out_tready = 1'b0;
  // victim, took_invalid, attempt, rejects, hit pos
  logic [lvs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [lvs_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [lvs_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [lvs_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  lru_set_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  lru_victim_select_with_qbs u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [lvs_pkg::IN_DATA_W-1:0] pack_in(logic [2:0] way,
                                                            logic [7:0] valid,
                                                            logic [7:0] elig,
                                                            logic [7:0] lower);
    return {5'b0, lower, elig, valid, way};
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (rst_n == 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (hold_off) begin
        stall = HOLD_CYCLES;
        hold_off = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      sb.check_result(out_tdata);
    end
  end

  task automatic push_item(input logic op, input logic [lvs_pkg::IN_DATA_W-1:0] data);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sb.accept_request(op, data);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [lvs_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [lvs_pkg::CFG_DATA_W-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == REG_ATTEMPT_LIMIT) sb.set_limit(val[lvs_pkg::LIMIT_W-1:0]);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int n);
    int r;
    logic [7:0] valid, elig, lower;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      elig = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom | $urandom);
      lower = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      if (r < 40) begin
        push_item(lvs_pkg::OP_TOUCH,
                  pack_in(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (r < 85) begin
        push_item(lvs_pkg::OP_VICTIM, pack_in(3'($urandom), 8'hFF, elig, lower));
      end else begin
        valid = (r < 92) ? ~(8'h01 << $urandom_range(0, 7)) : 8'($urandom);
        push_item(lvs_pkg::OP_VICTIM, pack_in(3'($urandom), valid, elig, lower));
      end
    end
  endtask

  initial begin
    logic [3:0] limits [10];
    limits = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd12, 4'd5, 4'd7, 4'd8};
    sb.reset_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit of one
    push_item(lvs_pkg::OP_TOUCH,  pack_in(3'd7, 8'h00, 8'h00, 8'h00));
    push_item(lvs_pkg::OP_TOUCH,  pack_in(3'd0, 8'hFF, 8'hFF, 8'hFF));
    push_item(lvs_pkg::OP_TOUCH,  pack_in(3'd7, 8'hFF, 8'hFF, 8'hFF));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'h00, 8'hFF, 8'hFF));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd7, 8'h7F, 8'hFF, 8'hFF));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'hFF, 8'hFF));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'h00, 8'hFF));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'h01, 8'h00));
    wait_drained();
    cfg_write(REG_ATTEMPT_LIMIT, 32'd8);
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'hFF, 8'hFF));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'hFF, 8'h00));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'hFF, 8'h55));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'h80, 8'h80));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'hFF, 8'hAA));
    push_item(lvs_pkg::OP_TOUCH,  pack_in(3'd3, 8'h00, 8'h00, 8'h00));
    push_item(lvs_pkg::OP_TOUCH,  pack_in(3'd5, 8'hFF, 8'hFF, 8'hFF));
    wait_drained();
    cfg_write(REG_ATTEMPT_LIMIT, 32'd0);
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'hFF, 8'hFF));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'h00, 8'hFF));
    wait_drained();
    cfg_write(REG_ATTEMPT_LIMIT, 32'd15);
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'hFF, 8'hFF));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd7, 8'hFE, 8'hFF, 8'hFF));
    push_item(lvs_pkg::OP_VICTIM, pack_in(3'd0, 8'hFF, 8'h7F, 8'hFE));
    push_item(lvs_pkg::OP_TOUCH,  pack_in(3'd7, 8'hFF, 8'hFF, 8'hFF));

    for (int p = 0; p < 10; p++) begin
      wait_drained();
      cfg_write(REG_ATTEMPT_LIMIT, {28'b0, (p == 6) ? 4'($urandom_range(9, 14)) : limits[p]});
      no_idle = (p == 3 || p == 5);
      if (p == 5) hold_off = 1'b1;
      run_random(PHASE_ITEMS);
    end
    wait_drained();

    sb.mismatches += sb.expected_results.size();
    $display("Ran %0d touches and %0d victim requests (%0d on an invalid way),",
             sb.n_touch, sb.n_victim, sb.n_invalid);
    $display("%0d limit writes, %0d rejections, %0d results checked, %0d mismatches.",
             sb.n_limits, sb.n_reject, sb.checked, sb.mismatches);
    if (sb.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lvs_pkg.sv
design/lvs_ctrl.sv
design/lvs_datapath.sv
design/lru_victim_select_with_qbs.sv
design/lvs_checker.sv
bench/lru_victim_select_with_qbs_test.sv
